// ----- rtl/rsi_pkg.sv -----
package rsi_pkg;

  // Field and state widths
  localparam int PRICE_W  = 32;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = 48;
  localparam int WIN_W    = 10;
  localparam int ITEMS_W  = 11;
  localparam int RSI_W    = 23;

  // Divider geometry
  localparam int NUM_W    = ACC_W + FRAC_W;      // dividend bits shifted in
  localparam int DEN_W    = ACC_W + 1;           // gain + loss needs one more bit
  localparam int STEP_W   = $clog2(NUM_W + 1);
  localparam int HUNDRED_W = 7;
  localparam int RATIO_N_W = ACC_W + HUNDRED_W + FRAC_W;

  localparam logic [ITEMS_W-1:0]   ITEMS_MAX  = '1;
  localparam logic [WIN_W-1:0]     WIN_RESET  = WIN_W'(14);
  localparam logic [HUNDRED_W-1:0] HUNDRED    = HUNDRED_W'(100);
  localparam logic [RSI_W-1:0]     RSI_HALF   = RSI_W'(50 << FRAC_W);
  localparam logic [RSI_W-1:0]     RSI_FULL   = RSI_W'(100 << FRAC_W);
  localparam logic [STEP_W-1:0]    STEPS_WIDE = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0]    STEPS_RSI  = STEP_W'(RSI_W);

  typedef enum logic [1:0] {
    DIV_NORM,
    DIV_SMOOTH,
    DIV_RATIO
  } div_op_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    STORE_NONE,
    STORE_GAIN,
    STORE_LOSS,
    STORE_RSI
  } store_e;

  typedef enum logic [1:0] {
    RSI_KEEP,
    RSI_SET_HALF,
    RSI_SET_FULL
  } rsi_set_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_ACCUM,
    PH_LAST,
    PH_SMOOTH
  } phase_e;

  typedef struct packed {
    acc_op_e  acc_op;
    rsi_set_e rsi_set;
    logic     div_start;
    div_op_e  div_op;
    logic     div_sel_loss;
    store_e   store;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   loss_zero;
    logic   div_done;
    logic   out_free;
  } sts_t;

endpackage

// ----- rtl/rsi_in_if.sv -----
interface rsi_in_if;
  logic                         valid;
  logic                         ready;
  logic [rsi_pkg::PRICE_W-1:0]  price;
  logic                         last_in_series;

  modport source (output valid, output price, output last_in_series, input ready);
  modport sink   (input valid, input price, input last_in_series, output ready);
endinterface

// ----- rtl/rsi_out_if.sv -----
interface rsi_out_if;
  logic                       valid;
  logic                       ready;
  logic [rsi_pkg::RSI_W-1:0]  rsi_value;
  logic                       series_end;

  modport source (output valid, output rsi_value, output series_end, input ready);
  modport sink   (input valid, input rsi_value, input series_end, output ready);
endinterface

// ----- rtl/rsi_div.sv -----
module rsi_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rsi_pkg::DEN_W-1:0]    rem_i,
  input  logic [rsi_pkg::NUM_W-1:0]    num_i,
  input  logic [rsi_pkg::DEN_W-1:0]    den_i,
  input  logic [rsi_pkg::STEP_W-1:0]   steps_i,
  output logic                         done_o,
  output logic [rsi_pkg::NUM_W-1:0]    quot_o
);
  import rsi_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] count_q;
  logic [DEN_W-1:0]  rem_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [NUM_W-1:0]  quot_q;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // restoring step: one quotient bit per cycle, MSB first
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        count_q <= steps_i;
      end else if (busy_q) begin
        count_q <= count_q - 1'b1;
        if (count_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      num_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      quot_q <= {quot_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/rsi_dp.sv -----
module rsi_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  logic [rsi_pkg::PRICE_W-1:0]   price_i,
  input  logic                          last_i,
  input  logic                          cfg_we_i,
  input  logic [rsi_pkg::WIN_W-1:0]     cfg_wdata_i,
  input  rsi_pkg::cmd_t                 cmd_i,
  output rsi_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rsi_pkg::RSI_W-1:0]     rsi_value_o,
  output logic                          series_end_o
);
  import rsi_pkg::*;

  logic [WIN_W-1:0]    win_q;
  logic [PRICE_W-1:0]  prev_q;
  logic [ITEMS_W-1:0]  items_q;
  logic [ACC_W-1:0]    gain_q;
  logic [ACC_W-1:0]    loss_q;
  logic                out_valid_q;

  logic [PRICE_W-1:0]  price_q;
  logic                last_q;
  logic [PRICE_W-1:0]  up_q;
  logic [PRICE_W-1:0]  down_q;
  logic [RSI_W-1:0]    rsi_q;
  logic [RSI_W-1:0]    out_rsi_q;
  logic                out_end_q;

  logic [WIN_W-1:0]          win_eff;
  logic [WIN_W-1:0]          win_m1;
  phase_e                    phase;
  logic [ACC_W-1:0]          acc_sel;
  logic [PRICE_W-1:0]        move_sel;
  logic [ACC_W+WIN_W-1:0]    smooth_prod;
  logic [NUM_W-1:0]          smooth_num;
  logic [ACC_W+HUNDRED_W-1:0] gain_x100;
  logic [RATIO_N_W-1:0]      ratio_n;
  logic [DEN_W-1:0]          div_rem;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic [STEP_W-1:0]         div_steps;
  logic                      div_done;
  logic [NUM_W-1:0]          div_quot;
  logic                      out_free;
  logic                      out_load;

  // a zero window behaves as one
  assign win_eff = (win_q == '0) ? WIN_W'(1) : win_q;
  assign win_m1  = win_eff - 1'b1;

  always_comb begin
    if (items_q == '0) begin
      phase = PH_FIRST;
    end else if (items_q < {1'b0, win_eff}) begin
      phase = PH_ACCUM;
    end else if (items_q == {1'b0, win_eff}) begin
      phase = PH_LAST;
    end else begin
      phase = PH_SMOOTH;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.emit && out_free;
  assign sts_o    = {phase, (loss_q == '0), div_done, out_free};

  // divider operand selection
  assign acc_sel     = cmd_i.div_sel_loss ? loss_q : gain_q;
  assign move_sel    = cmd_i.div_sel_loss ? down_q : up_q;
  assign smooth_prod = acc_sel * win_m1;
  assign smooth_num  = NUM_W'(smooth_prod) + NUM_W'({move_sel, {FRAC_W{1'b0}}});
  assign gain_x100   = gain_q * HUNDRED;
  assign ratio_n     = {gain_x100, {FRAC_W{1'b0}}};

  always_comb begin
    case (cmd_i.div_op)
      DIV_SMOOTH: begin
        div_rem   = '0;
        div_num   = smooth_num;
        div_den   = DEN_W'(win_eff);
        div_steps = STEPS_WIDE;
      end
      DIV_RATIO: begin
        // quotient fits RSI_W bits, so the upper dividend bits preload the remainder
        div_rem   = DEN_W'(ratio_n[RATIO_N_W-1:RSI_W]);
        div_num   = {ratio_n[RSI_W-1:0], {(NUM_W-RSI_W){1'b0}}};
        div_den   = {1'b0, gain_q} + {1'b0, loss_q};
        div_steps = STEPS_RSI;
      end
      default: begin
        div_rem   = '0;
        div_num   = {acc_sel, {FRAC_W{1'b0}}};
        div_den   = DEN_W'(win_eff);
        div_steps = STEPS_WIDE;
      end
    endcase
  end

  rsi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .rem_i   (div_rem),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RESET;
      prev_q      <= '0;
      items_q     <= '0;
      gain_q      <= '0;
      loss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end

      case (cmd_i.acc_op)
        ACC_CLEAR: begin
          gain_q <= '0;
          loss_q <= '0;
        end
        ACC_ADD: begin
          gain_q <= gain_q + ACC_W'(up_q);
          loss_q <= loss_q + ACC_W'(down_q);
        end
        default: begin
        end
      endcase

      case (cmd_i.store)
        STORE_GAIN: gain_q <= div_quot[ACC_W-1:0];
        STORE_LOSS: loss_q <= div_quot[ACC_W-1:0];
        default: begin
        end
      endcase

      // the series position and previous price commit with the result beat
      if (out_load) begin
        out_valid_q <= 1'b1;
        prev_q      <= price_q;
        if (last_q) begin
          items_q <= '0;
        end else if (items_q != ITEMS_MAX) begin
          items_q <= items_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      price_q <= price_i;
      last_q  <= last_i;
      up_q    <= (price_i > prev_q) ? price_i - prev_q : '0;
      down_q  <= (prev_q > price_i) ? prev_q - price_i : '0;
    end

    case (cmd_i.rsi_set)
      RSI_SET_HALF: rsi_q <= RSI_HALF;
      RSI_SET_FULL: rsi_q <= RSI_FULL;
      default: begin
        if (cmd_i.store == STORE_RSI) begin
          rsi_q <= div_quot[RSI_W-1:0];
        end
      end
    endcase

    if (out_load) begin
      out_rsi_q <= rsi_q;
      out_end_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rsi_value_o  = out_rsi_q;
  assign series_end_o = out_end_q;

endmodule

// ----- rtl/rsi_ctrl.sv -----
module rsi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  rsi_pkg::sts_t  sts_i,
  output rsi_pkg::cmd_t  cmd_o,
  output logic           in_ready_o
);
  import rsi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_NORM,
    ST_DIV_G,
    ST_DIV_L,
    ST_RSI_WAIT,
    ST_RSI_CHK,
    ST_DIV_R,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e state_q;
  state_e state_d;
  cmd_t   cmd_q;
  cmd_t   cmd_d;
  logic   ready_q;
  logic   ready_d;
  logic   smooth_q;
  logic   smooth_d;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    ready_d  = ready_q;
    smooth_d = smooth_q;

    // single-cycle commands
    cmd_d.acc_op    = ACC_HOLD;
    cmd_d.rsi_set   = RSI_KEEP;
    cmd_d.div_start = 1'b0;
    cmd_d.store     = STORE_NONE;

    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          ready_d = 1'b0;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        case (sts_i.phase)
          PH_FIRST: begin
            cmd_d.acc_op  = ACC_CLEAR;
            cmd_d.rsi_set = RSI_SET_HALF;
            state_d       = ST_FINISH;
          end
          PH_ACCUM: begin
            cmd_d.acc_op  = ACC_ADD;
            cmd_d.rsi_set = RSI_SET_HALF;
            state_d       = ST_FINISH;
          end
          PH_LAST: begin
            cmd_d.acc_op  = ACC_ADD;
            cmd_d.rsi_set = RSI_SET_HALF;
            smooth_d      = 1'b0;
            state_d       = ST_NORM;
          end
          default: begin
            cmd_d.div_start    = 1'b1;
            cmd_d.div_op       = DIV_SMOOTH;
            cmd_d.div_sel_loss = 1'b0;
            smooth_d           = 1'b1;
            state_d            = ST_DIV_G;
          end
        endcase
      end
      ST_NORM: begin
        // sums are final now; turn them into averages
        cmd_d.div_start    = 1'b1;
        cmd_d.div_op       = DIV_NORM;
        cmd_d.div_sel_loss = 1'b0;
        state_d            = ST_DIV_G;
      end
      ST_DIV_G: begin
        if (sts_i.div_done) begin
          cmd_d.store        = STORE_GAIN;
          cmd_d.div_start    = 1'b1;
          cmd_d.div_sel_loss = 1'b1;
          state_d            = ST_DIV_L;
        end
      end
      ST_DIV_L: begin
        if (sts_i.div_done) begin
          cmd_d.store = STORE_LOSS;
          state_d     = smooth_q ? ST_RSI_WAIT : ST_FINISH;
        end
      end
      ST_RSI_WAIT: begin
        state_d = ST_RSI_CHK;
      end
      ST_RSI_CHK: begin
        if (sts_i.loss_zero) begin
          cmd_d.rsi_set = RSI_SET_FULL;
          state_d       = ST_FINISH;
        end else begin
          cmd_d.div_start = 1'b1;
          cmd_d.div_op    = DIV_RATIO;
          state_d         = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (sts_i.div_done) begin
          cmd_d.store = STORE_RSI;
          state_d     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_d.emit = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_d.emit = 1'b0;
          ready_d    = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        cmd_d.emit = 1'b0;
        ready_d    = 1'b1;
        state_d    = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cmd_q    <= '0;
      ready_q  <= 1'b1;
      smooth_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      ready_q  <= ready_d;
      smooth_q <= smooth_d;
    end
  end

  assign cmd_o      = cmd_q;
  assign in_ready_o = ready_q;

endmodule

// ----- rtl/relative_strength_index_unit.sv -----
// Throughput: one item at a time. Seed and summing items need no division; the item
//   that closes the window takes two 64-step divisions, and a smoothing item two 64-step
//   divisions and, unless the smoothed loss is zero, one 23-step one,
//   all on the shared bit-serial divider.
// The result register lets the next price be taken while a result beat waits.
// Reset (rst_ni, async, active low) clears all series state and sets the window to 14.
module relative_strength_index_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rsi_in_if.sink                    in_i,
  rsi_out_if.source                 out_o,
  input  logic                      cfg_we_i,
  input  logic [rsi_pkg::WIN_W-1:0] cfg_wdata_i
);
  import rsi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic in_fire;

  assign in_fire  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  rsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  rsi_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .price_i      (in_i.price),
    .last_i       (in_i.last_in_series),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .rsi_value_o  (out_o.rsi_value),
    .series_end_o (out_o.series_end)
  );

endmodule

// ----- rtl/rsi_chk.sv -----
module rsi_chk (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [rsi_pkg::RSI_W-1:0] rsi_value_i,
  input  logic                      series_end_i
);
  import rsi_pkg::*;

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // and keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(rsi_value_i) && $stable(series_end_i))
    else $error("result payload changed while stalled");

  // RSI never exceeds 100.0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> rsi_value_i <= RSI_FULL)
    else $error("rsi_value out of range");

  // one price at a time: the unit is busy right after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while previous price in flight");

  // no result can appear the cycle after an input beat into an empty output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result beat without processing time");

endmodule

bind relative_strength_index_unit rsi_chk u_rsi_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .rsi_value_i  (out_o.rsi_value),
  .series_end_i (out_o.series_end)
);
